/* src/rational_arithmetic_unit_defines.svh */
// Assertion macros used by the port checker of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/rau_pkg.sv */
// Package with types, constants and opcodes of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OPERAND_BITS = 32;
    localparam int WIDE_BITS    = 64;
    localparam int CNT_BITS     = 7;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } t_op;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_req;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         order;
        logic               div_zero;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FORM,
        S_GCD_START,
        S_GCD_WAIT,
        S_DIVN_START,
        S_DIVN_WAIT,
        S_DIVD_START,
        S_DIVD_WAIT,
        S_DONE
    } t_state;

    // Commands and status between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } t_div_sts;
endpackage

/* src/rau_divider.sv */
// Radix-2 restoring divider for 64-bit unsigned values, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider
    import rau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_sts o_sts
);
    logic [63:0]         r_rem, n_rem;
    logic [63:0]         r_quot, n_quot;
    logic [63:0]         r_dvs, n_dvs;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [64:0]         w_trial;
    logic [64:0]         w_diff;

    // One shift-subtract step per cycle.
    always_comb begin
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quot[63]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (i_cmd.start) begin
            n_rem  = '0;
            n_quot = i_cmd.dividend;
            n_dvs  = i_cmd.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                n_rem  = w_diff[63:0];
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem  = w_trial[63:0];
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(WIDE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.quot = r_quot;
    assign o_sts.rem  = r_rem;
endmodule

/* src/rau_gcd.sv */
// Binary gcd engine for 64-bit magnitudes, one subtract-and-shift step per cycle.
`timescale 1ns / 1ps
module rau_gcd
    import rau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    output logic        o_done,
    output logic [63:0] o_gcd
);
    logic [63:0]         r_u, n_u;
    logic [63:0]         r_v, n_v;
    logic [CNT_BITS-1:0] r_k, n_k;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [63:0]         w_diff;

    // Stein's algorithm: strip common twos, then subtract and shift.
    always_comb begin
        n_u    = r_u;
        n_v    = r_v;
        n_k    = r_k;
        n_busy = r_busy;
        n_done = 1'b0;
        w_diff = (r_u > r_v) ? (r_u - r_v) : (r_v - r_u);
        if (i_start) begin
            n_u    = i_x;
            n_v    = i_y;
            n_k    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_u == 64'd0) begin
                n_u    = r_v << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_v == 64'd0) begin
                n_u    = r_u << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_u[0] && !r_v[0]) begin
                n_u = r_u >> 1;
                n_v = r_v >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_u[0]) begin
                n_u = r_u >> 1;
            end else if (!r_v[0]) begin
                n_v = r_v >> 1;
            end else if (r_u > r_v) begin
                n_u = w_diff;
            end else begin
                n_v = w_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_u <= n_u;
        r_v <= n_v;
        r_k <= n_k;
    end

    assign o_done = r_done;
    assign o_gcd  = r_u;
endmodule

/* src/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: sequencer, multiplier and result register.
//
// One transaction at a time: the unit takes a request, forms the 64-bit cross
// products on one shared 32x32 multiplier in the states S_MUL1 to S_MUL3, reduces
// the result with a binary gcd engine and divides numerator and denominator by the
// gcd on one shared radix-2 divider, while compare, unused codes and zero
// denominators skip the gcd and the divisions. The result is held in an output
// register until taken, and the input ready is low from acceptance until the
// result has been taken.
`timescale 1ns / 1ps
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);
    t_state              r_state, n_state;
    t_req                r_req;
    logic signed [63:0]  r_p0, r_p1, r_p2, n_prod;
    logic [63:0]         r_mn, r_md, r_g;
    logic                r_neg;
    t_rsp                r_rsp, n_rsp;
    logic                r_ovalid, n_ovalid;
    logic signed [31:0]  w_ma, w_mb;
    logic signed [63:0]  w_num, w_den, w_diff;
    logic [63:0]         w_mn, w_md;
    logic                w_gcd_start, w_gcd_done;
    logic [63:0]         w_gcd;
    t_div_cmd            w_cmd;
    t_div_sts            w_sts;
    logic [2:0]          w_op;

    assign w_op = r_req.req_type;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = r_req.a_num;
        w_mb = $signed({1'b0, r_req.b_den});
        case (r_state)
            S_MUL1: begin
                w_ma = r_req.a_num;
                w_mb = (w_op == OP_MUL) ? r_req.b_num : $signed({1'b0, r_req.b_den});
            end
            S_MUL2: begin
                w_ma = r_req.b_num;
                w_mb = $signed({1'b0, r_req.a_den});
            end
            S_MUL3: begin
                w_ma = $signed({1'b0, r_req.a_den});
                w_mb = (w_op == OP_DIV) ? r_req.b_num : $signed({1'b0, r_req.b_den});
            end
            default: begin
                w_ma = r_req.a_num;
                w_mb = $signed({1'b0, r_req.b_den});
            end
        endcase
        n_prod = 64'(w_ma) * 64'(w_mb);
    end

    // Numerator and denominator from the products.
    always_comb begin
        w_diff = r_p0 - r_p1;
        case (w_op)
            OP_ADD:  w_num = r_p0 + r_p1;
            OP_SUB:  w_num = w_diff;
            default: w_num = r_p0;
        endcase
        w_den = r_p2;
        w_mn  = w_num[63] ? (64'd0 - w_num) : w_num;
        w_md  = w_den[63] ? (64'd0 - w_den) : w_den;
    end

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (r_mn),
        .i_y     (r_md),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    rau_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    // Sequencer: next state, unit commands and result.
    always_comb begin
        n_state      = r_state;
        n_rsp        = r_rsp;
        n_ovalid     = r_ovalid;
        w_gcd_start  = 1'b0;
        w_cmd.start    = 1'b0;
        w_cmd.dividend = r_mn;
        w_cmd.divisor  = r_g;
        o_ready      = (r_state == S_IDLE) && !r_ovalid;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_FORM;
            S_FORM: begin
                n_rsp.res_num  = '0;
                n_rsp.res_den  = '0;
                n_rsp.order    = ORD_EQUAL;
                n_rsp.div_zero = 1'b0;
                if (w_op == OP_CMP) begin
                    if (r_p0 < r_p1)      n_rsp.order = ORD_LESS;
                    else if (r_p0 > r_p1) n_rsp.order = ORD_GREATER;
                    n_state = S_DONE;
                end else if (w_op > OP_CMP) begin
                    n_state = S_DONE;
                end else if (w_den == 64'sd0) begin
                    n_rsp.div_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_GCD_START;
                end
            end
            S_GCD_START: begin
                w_gcd_start = 1'b1;
                n_state     = S_GCD_WAIT;
            end
            S_GCD_WAIT: begin
                if (w_gcd_done) n_state = S_DIVN_START;
            end
            S_DIVN_START: begin
                w_cmd.start = 1'b1;
                n_state     = S_DIVN_WAIT;
            end
            S_DIVN_WAIT: begin
                if (w_sts.done) n_state = S_DIVD_START;
            end
            S_DIVD_START: begin
                w_cmd.start    = 1'b1;
                w_cmd.dividend = r_md;
                n_state        = S_DIVD_WAIT;
            end
            S_DIVD_WAIT: begin
                if (w_sts.done) begin
                    n_rsp.res_num = r_neg ? (64'sd0 - $signed(r_mn)) : $signed(r_mn);
                    n_rsp.res_den = (r_mn == 64'd0) ? 63'd1 : w_sts.quot[62:0];
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_rsp <= n_rsp;
        if (i_valid && o_ready) r_req <= i_req;
        if (r_state == S_MUL1) r_p0 <= n_prod;
        if (r_state == S_MUL2) r_p1 <= n_prod;
        if (r_state == S_MUL3) r_p2 <= n_prod;
        if (r_state == S_FORM) begin
            r_mn  <= w_mn;
            r_md  <= w_md;
            r_neg <= w_num[63] != w_den[63];
        end
        if (r_state == S_GCD_WAIT && w_gcd_done) r_g <= w_gcd;
        if (r_state == S_DIVN_WAIT && w_sts.done) r_mn <= w_sts.quot;
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
endmodule

/* src/rau_checker.sv */
// Port-level checker for the rational arithmetic unit and its bind statement.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rau_port_checker
    import rau_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);
    // A held result keeps its value until taken.
    `RAU_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_rsp))
    // No new transaction while a result waits.
    `RAU_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, !o_ready)
    // An accepted request makes the unit busy next cycle.
    `RAU_ASSERT_NXT(a_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // Error results carry a zero denominator.
    `RAU_ASSERT_IMP(a_err, i_clk, i_rst_n, o_valid && o_rsp.div_zero, o_rsp.res_den == 63'd0)
endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);

/* dv/rau_checker.sv */
// Checker for the rational arithmetic unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module rau_checker
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_ready_in,
    input  t_req i_req,
    input  logic i_valid_out,
    input  logic i_ready,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending
);
    t_rsp expected_rsps[$];

    // Magnitude of a signed 64-bit value as unsigned.
    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // Euclidean gcd of two magnitudes.
    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce a fraction to lowest terms with a positive denominator.
    function automatic t_rsp reduce_fraction(input logic signed [63:0] num,
                                             input logic signed [63:0] den);
        t_rsp r;
        logic [63:0] mn, md, g;
        r = '0;
        r.order = ORD_EQUAL;
        if (den == 0) begin
            r.div_zero = 1'b1;
            return r;
        end
        mn = magnitude(num);
        md = magnitude(den);
        g = euclid_gcd(mn, md);
        mn = mn / g;
        md = md / g;
        if (mn == 0) md = 64'd1;
        r.res_num = ((num < 0) != (den < 0)) ? 64'd0 - mn : mn;
        r.res_den = md[62:0];
        return r;
    endfunction

    // Expected response for one request.
    function automatic t_rsp predict_rsp(input t_req q);
        t_rsp r;
        logic signed [63:0] an, bn, ad, bd, l, rr;
        an = 64'(q.a_num);
        bn = 64'(q.b_num);
        ad = {33'd0, q.a_den};
        bd = {33'd0, q.b_den};
        r = '0;
        r.order = ORD_EQUAL;
        case (q.req_type)
            OP_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
            OP_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
            OP_MUL: r = reduce_fraction(an * bn, ad * bd);
            OP_DIV: r = reduce_fraction(an * bd, ad * bn);
            OP_CMP: begin
                l = an * bd;
                rr = ad * bn;
                r.order = l < rr ? ORD_LESS : (l > rr ? ORD_GREATER : ORD_EQUAL);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Queue a prediction on each request transaction, compare on each response.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_valid && i_ready_in) expected_rsps.push_back(predict_rsp(i_req));
            if (i_valid_out && i_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.res_num !== i_rsp.res_num || want.res_den !== i_rsp.res_den ||
                        want.order !== i_rsp.order || want.div_zero !== i_rsp.div_zero) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, i_rsp);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_rsps.size();
endmodule

/* dv/tb.sv */
// Testbench top for the rational arithmetic unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
    import rau_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;
    int errors;
    int pending;
    int cycles = 0;
    logic hold_off = 1'b0;
    t_req directed_reqs[$];

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 3000000;

    always #2 i_clk = ~i_clk;

    rational_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    rau_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_req(i_req), .i_valid_out(o_valid), .i_ready(i_ready), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending)
    );

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stalls on its own pattern; one long hold-off fills the unit.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_off) i_ready <= 1'b0;
        else if (cycles[9:7] == 3'd5) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        @(posedge i_clk);
        wait (i_rst_n);
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Random numerator, biased toward extremes and small values.
    function automatic logic [31:0] random_num();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    // Random denominator; zero occasionally for the divide-by-zero path.
    function automatic logic [30:0] random_den();
        case ($urandom_range(0, 7))
            0: return 31'h7fff_ffff;
            1: return 31'd0;
            2: return 31'($urandom_range(1, 12));
            default: return 31'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until the transaction completes.
    task automatic send_req(input t_req q);
        i_valid <= 1'b1;
        i_req <= q;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    initial begin
        t_req q;
        int burst;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation, extremes, zero results and zero denominators.
        for (int op = 0; op < 5; op++) begin
            directed_reqs.push_back('{3'(op), 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1});
            directed_reqs.push_back('{3'(op), 32'h7fff_ffff, 31'h7fff_ffff,
                                      32'h8000_0000, 31'h7fff_ffff});
            directed_reqs.push_back('{3'(op), 32'sd3, 31'd4, 32'sd0, 31'd7});
            directed_reqs.push_back('{3'(op), -32'sd6, 31'd8, 32'sd3, 31'd0});
        end
        directed_reqs.push_back('{OP_ADD, 32'sd1, 31'd2, -32'sd1, 31'd2});
        directed_reqs.push_back('{OP_CMP, 32'sd1, 31'd2, 32'sd2, 31'd4});
        directed_reqs.push_back('{3'd5, 32'sd1, 31'd2, 32'sd1, 31'd3});
        directed_reqs.push_back('{3'd7, -32'sd1, 31'h7fff_ffff, 32'sd9, 31'd3});
        foreach (directed_reqs[i]) send_req(directed_reqs[i]);

        // Random bursts with random gaps.
        for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                q.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4));
                q.a_num = random_num();
                q.a_den = random_den();
                q.b_num = random_num();
                q.b_den = random_den();
                send_req(q);
            end
            // Drop valid only when an idle gap follows the burst.
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // Drain and settle.
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
